@@ rtl/exl_pkg.sv @@
// Shared types and constants for the expression lexer.
package exl_pkg;

    localparam int unsigned SLOTS     = 4;
    localparam int unsigned QDEPTH    = 8;
    localparam int unsigned QPTR_W    = $clog2(QDEPTH);
    localparam int unsigned MAX_STEP  = 3;

    typedef enum logic [3:0] {
        KIND_END    = 4'd0,
        KIND_NUM    = 4'd1,
        KIND_IDENT  = 4'd2,
        KIND_STR    = 4'd3,
        KIND_IF     = 4'd4,
        KIND_VAR    = 4'd5,
        KIND_ELSE   = 4'd6,
        KIND_SINGLE = 4'd7,
        KIND_DOUBLE = 4'd8,
        KIND_ERR    = 4'd9
    } tok_kind_t;

    localparam logic [7:0] OP_LE   = 8'd0;
    localparam logic [7:0] OP_SHL  = 8'd1;
    localparam logic [7:0] OP_GE   = 8'd2;
    localparam logic [7:0] OP_SHR  = 8'd3;
    localparam logic [7:0] OP_NE   = 8'd4;
    localparam logic [7:0] OP_EQ   = 8'd5;
    localparam logic [7:0] OP_LAND = 8'd6;
    localparam logic [7:0] OP_LOR  = 8'd7;

    localparam logic [7:0] ERR_STRING = 8'd0;
    localparam logic [7:0] ERR_HEX    = 8'd1;

    localparam logic [7:0]  CTRL_LIMIT = 8'h20;
    localparam logic [31:0] KW_IF      = 32'h0000_6966;
    localparam logic [31:0] KW_VAR     = 32'h0076_6172;
    localparam logic [31:0] KW_ELSE    = 32'h656C_7365;

    typedef struct packed {
        tok_kind_t   kind;
        logic [7:0]  code;
        logic [15:0] start_ofs;
        logic [15:0] end_ofs;
        logic [63:0] value;
        logic [15:0] line;
        logic        run_last;
    } res_t;

endpackage

@@ rtl/exl_in_if.sv @@
// Input channel: one text byte per transfer.
interface exl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

@@ rtl/exl_out_if.sv @@
// Output channel: one token per transfer.
interface exl_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [7:0]  token_code;
    logic [15:0] start_offset;
    logic [15:0] end_offset;
    logic [63:0] number_value;
    logic [15:0] line_number;
    logic        run_last;

    modport source (output valid, output token_kind, output token_code,
                    output start_offset, output end_offset, output number_value,
                    output line_number, output run_last, input ready);
    modport sink (input valid, input token_kind, input token_code,
                  input start_offset, input end_offset, input number_value,
                  input line_number, input run_last, output ready);
endinterface

@@ rtl/expression_lexer.sv @@
// Expression lexer top level: input register, scan step and result queue.
//
// Streaming tokenizer for C-style expression text, one byte per transfer, the
// final byte of a text flagged by end_of_text. Each accepted byte is held in
// an input register and scanned from there once the queue has room; its tokens
// (zero to three) land in an eight-entry result queue that drives the output
// channel. A token normally appears once the byte after it arrives. Input runs
// at one byte per cycle while the output keeps up; the output port gives one
// token per cycle while the receiver is ready, one transfer for each token of a
// byte, and the input stalls only when the queue holds more than five tokens.
// Byte offsets count modulo MAX_TEXT_BYTES and are reported as their low 16
// bits. After an error no further tokens appear until the final byte of the
// text, where all state returns to its reset values.
module expression_lexer
    import exl_pkg::*;
#(
    parameter int unsigned MAX_TEXT_BYTES = 65536
)
(
    input logic       clk,
    input logic       rst_n,
    exl_in_if.sink    text_in,
    exl_out_if.source token_out
);

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_last_reg;
    logic             step;
    logic             room;
    res_t             slot [SLOTS];
    logic [SLOTS-1:0] slot_valid;
    res_t             head;

    assign step          = in_valid_reg && room;
    assign text_in.ready = !in_valid_reg || room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (text_in.ready)
        begin
            in_valid_reg <= text_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_in.ready && text_in.valid)
        begin
            in_byte_reg <= text_in.text_byte;
            in_last_reg <= text_in.end_of_text;
        end
    end

    exl_scan #(
        .MAX_TEXT_BYTES (MAX_TEXT_BYTES)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .text_byte   (in_byte_reg),
        .end_of_text (in_last_reg),
        .slot        (slot),
        .slot_valid  (slot_valid)
    );

    exl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (step),
        .slot       (slot),
        .slot_valid (slot_valid),
        .room       (room),
        .out_valid  (token_out.valid),
        .out_ready  (token_out.ready),
        .out_data   (head)
    );

    assign token_out.token_kind   = head.kind;
    assign token_out.token_code   = head.code;
    assign token_out.start_offset = head.start_ofs;
    assign token_out.end_offset   = head.end_ofs;
    assign token_out.number_value = head.value;
    assign token_out.line_number  = head.line;
    assign token_out.run_last     = head.run_last;

endmodule

@@ rtl/exl_scan.sv @@
// Lexer state and the per-byte scan step filling up to three of its four token slots.
module exl_scan
    import exl_pkg::*;
#(
    parameter int unsigned MAX_TEXT_BYTES = 65536
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       text_byte,
    input  logic             end_of_text,
    output res_t             slot [SLOTS],
    output logic [SLOTS-1:0] slot_valid
);

    localparam int unsigned OFS_W = $clog2(MAX_TEXT_BYTES);
    localparam logic [OFS_W-1:0] OFS_LAST = OFS_W'(MAX_TEXT_BYTES - 1);

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_SLASH,
        MODE_LINE,
        MODE_BLOCK,
        MODE_STAR,
        MODE_STRING,
        MODE_ESC,
        MODE_ZERO,
        MODE_HEXS,
        MODE_HEX,
        MODE_DEC,
        MODE_IDENT,
        MODE_OP
    } scan_mode_t;

    scan_mode_t       mode_reg, mode_next;
    logic [7:0]       held_reg, held_next;
    logic [OFS_W-1:0] offset_reg, offset_next;
    logic [OFS_W-1:0] tstart_reg, tstart_next;
    logic [63:0]      acc_reg, acc_next;
    logic [31:0]      prefix_reg, prefix_next;
    logic [2:0]       ilen_reg, ilen_next;
    logic [15:0]      line_reg, line_next;
    logic             halted_reg, halted_next;
    logic [15:0]      tline_reg, tline_next;

    res_t             slot_c [SLOTS];
    logic [SLOTS-1:0] valid_c;

    function automatic logic [15:0] to16(input logic [OFS_W-1:0] x);
        logic [OFS_W+15:0] w;
        w = (OFS_W + 16)'(x);
        return w[15:0];
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c == "@") || (c == "_") || ((c >= "A") && (c <= "Z"))
            || ((c >= "a") && (c <= "z"));
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || ((c >= "A") && (c <= "F")) || ((c >= "a") && (c <= "f"));
    endfunction

    function automatic logic [3:0] hex_digit(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (is_digit(c))
        begin
            d = c - "0";
        end
        else if ((c >= "A") && (c <= "F"))
        begin
            d = c - "A" + 8'd10;
        end
        else if ((c >= "a") && (c <= "f"))
        begin
            d = c - "a" + 8'd10;
        end
        return d[3:0];
    endfunction

    function automatic logic is_op_char(input logic [7:0] c);
        return (c == "<") || (c == ">") || (c == "!") || (c == "=") || (c == "&")
            || (c == "|");
    endfunction

    function automatic logic [8:0] pair_code(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] r;
        r = 9'd0;
        if ((a == "<") && (b == "="))      r = {1'b1, OP_LE};
        else if ((a == "<") && (b == "<")) r = {1'b1, OP_SHL};
        else if ((a == ">") && (b == "=")) r = {1'b1, OP_GE};
        else if ((a == ">") && (b == ">")) r = {1'b1, OP_SHR};
        else if ((a == "!") && (b == "=")) r = {1'b1, OP_NE};
        else if ((a == "=") && (b == "=")) r = {1'b1, OP_EQ};
        else if ((a == "&") && (b == "&")) r = {1'b1, OP_LAND};
        else if ((a == "|") && (b == "|")) r = {1'b1, OP_LOR};
        return r;
    endfunction

    function automatic tok_kind_t ident_kind(input logic [31:0] p, input logic [2:0] n);
        tok_kind_t k;
        k = KIND_IDENT;
        if ((n == 3'd2) && (p == KW_IF))        k = KIND_IF;
        else if ((n == 3'd3) && (p == KW_VAR))  k = KIND_VAR;
        else if ((n == 3'd4) && (p == KW_ELSE)) k = KIND_ELSE;
        return k;
    endfunction

    function automatic res_t mk(input tok_kind_t k, input logic [7:0] code,
                                input logic [OFS_W-1:0] s, input logic [OFS_W-1:0] e,
                                input logic [63:0] v, input logic [15:0] ln);
        res_t r;
        r.kind      = k;
        r.code      = code;
        r.start_ofs = to16(s);
        r.end_ofs   = to16(e);
        r.value     = v;
        r.line      = ln;
        r.run_last  = 1'b0;
        return r;
    endfunction

    always_comb
    begin
        logic [OFS_W-1:0] pos;
        logic [OFS_W-1:0] nxt;
        logic [7:0]       c;
        logic             fall;
        logic             bump;
        logic [8:0]       pc;
        logic [63:0]      dec_val;
        logic             later;

        c    = text_byte;
        pos  = offset_reg;
        nxt  = (offset_reg == OFS_LAST) ? '0 : offset_reg + 1'b1;
        fall = 1'b0;
        bump = 1'b0;
        pc   = pair_code(held_reg, c);
        dec_val = {acc_reg[60:0], 3'b000} + {acc_reg[62:0], 1'b0} + 64'(c - "0");

        mode_next   = mode_reg;
        held_next   = held_reg;
        tstart_next = tstart_reg;
        acc_next    = acc_reg;
        prefix_next = prefix_reg;
        ilen_next   = ilen_reg;
        halted_next = halted_reg;
        tline_next  = tline_reg;
        offset_next = nxt;
        valid_c     = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_c[i] = mk(KIND_END, 8'd0, '0, '0, 64'd0, 16'd0);
        end

        if (!halted_reg)
        begin
            unique case (mode_reg)
                MODE_IDLE:
                begin
                    fall = 1'b1;
                end
                MODE_SLASH:
                begin
                    if (c == "/")
                    begin
                        mode_next = MODE_LINE;
                    end
                    else if (c == "*")
                    begin
                        mode_next = MODE_BLOCK;
                    end
                    else
                    begin
                        slot_c[0]  = mk(KIND_SINGLE, "/", tstart_reg, pos, 64'd0, tline_reg);
                        valid_c[0] = 1'b1;
                        fall       = 1'b1;
                    end
                end
                MODE_LINE:
                begin
                    if (c == "\n")
                    begin
                        bump      = 1'b1;
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_BLOCK:
                begin
                    if (c == "*")
                    begin
                        mode_next = MODE_STAR;
                    end
                    else if (c == "\n")
                    begin
                        bump = 1'b1;
                    end
                end
                MODE_STAR:
                begin
                    if (c == "/")
                    begin
                        mode_next = MODE_IDLE;
                    end
                    else if (c != "*")
                    begin
                        bump      = (c == "\n");
                        mode_next = MODE_BLOCK;
                    end
                end
                MODE_STRING:
                begin
                    if (c == "\"")
                    begin
                        slot_c[1]  = mk(KIND_STR, 8'd0, tstart_reg, pos, 64'd0, tline_reg);
                        valid_c[1] = 1'b1;
                        mode_next  = MODE_IDLE;
                    end
                    else if (c == "\\")
                    begin
                        mode_next = MODE_ESC;
                    end
                    else if (c == "\n")
                    begin
                        bump = 1'b1;
                    end
                    else if ((c < CTRL_LIMIT) && (c != "\r") && (c != "\t"))
                    begin
                        slot_c[1]   = mk(KIND_ERR, ERR_STRING, tstart_reg, pos, 64'd0,
                                         tline_reg);
                        valid_c[1]  = 1'b1;
                        halted_next = 1'b1;
                    end
                end
                MODE_ESC:
                begin
                    bump      = (c == "\n");
                    mode_next = MODE_STRING;
                end
                MODE_HEXS:
                begin
                    if (is_hex(c))
                    begin
                        acc_next  = 64'(hex_digit(c));
                        mode_next = MODE_HEX;
                    end
                    else
                    begin
                        slot_c[1]   = mk(KIND_ERR, ERR_HEX, tstart_reg, pos, 64'd0, tline_reg);
                        valid_c[1]  = 1'b1;
                        halted_next = 1'b1;
                    end
                end
                MODE_HEX:
                begin
                    if (is_hex(c))
                    begin
                        acc_next = {acc_reg[59:0], hex_digit(c)};
                    end
                    else
                    begin
                        slot_c[0]  = mk(KIND_NUM, 8'd0, tstart_reg, pos, acc_reg, tline_reg);
                        valid_c[0] = 1'b1;
                        fall       = 1'b1;
                    end
                end
                MODE_ZERO, MODE_DEC:
                begin
                    if ((mode_reg == MODE_ZERO) && ((c == "x") || (c == "X")))
                    begin
                        mode_next = MODE_HEXS;
                    end
                    else if (is_digit(c))
                    begin
                        acc_next  = dec_val;
                        mode_next = MODE_DEC;
                    end
                    else
                    begin
                        slot_c[0]  = mk(KIND_NUM, 8'd0, tstart_reg, pos, acc_reg, tline_reg);
                        valid_c[0] = 1'b1;
                        fall       = 1'b1;
                    end
                end
                MODE_IDENT:
                begin
                    if (is_alpha(c) || is_digit(c))
                    begin
                        if (ilen_reg < 3'd4)
                        begin
                            prefix_next = {prefix_reg[23:0], c};
                        end
                        if (ilen_reg < 3'd5)
                        begin
                            ilen_next = ilen_reg + 3'd1;
                        end
                    end
                    else
                    begin
                        slot_c[0]  = mk(ident_kind(prefix_reg, ilen_reg), 8'd0, tstart_reg, pos,
                                        64'd0, tline_reg);
                        valid_c[0] = 1'b1;
                        fall       = 1'b1;
                    end
                end
                MODE_OP:
                begin
                    if (pc[8])
                    begin
                        slot_c[1]  = mk(KIND_DOUBLE, pc[7:0], tstart_reg, nxt, 64'd0, tline_reg);
                        valid_c[1] = 1'b1;
                        mode_next  = MODE_IDLE;
                    end
                    else
                    begin
                        slot_c[0]  = mk(KIND_SINGLE, held_reg, tstart_reg, pos, 64'd0,
                                        tline_reg);
                        valid_c[0] = 1'b1;
                        fall       = 1'b1;
                    end
                end
                default:
                begin
                    fall = 1'b1;
                end
            endcase

            // byte starts a fresh token (or is skipped)
            if (fall)
            begin
                mode_next = MODE_IDLE;
                if ((c == " ") || (c == "\t") || (c == "\r"))
                begin
                    mode_next = MODE_IDLE;
                end
                else if (c == "\n")
                begin
                    bump = 1'b1;
                end
                else
                begin
                    tstart_next = pos;
                    tline_next  = line_reg;
                    if (c == "/")
                    begin
                        mode_next = MODE_SLASH;
                    end
                    else if (c == "\"")
                    begin
                        tstart_next = nxt;
                        mode_next   = MODE_STRING;
                    end
                    else if (c == "0")
                    begin
                        acc_next  = 64'd0;
                        mode_next = MODE_ZERO;
                    end
                    else if (is_digit(c))
                    begin
                        acc_next  = 64'(c - "0");
                        mode_next = MODE_DEC;
                    end
                    else if (is_alpha(c))
                    begin
                        prefix_next = 32'(c);
                        ilen_next   = 3'd1;
                        mode_next   = MODE_IDENT;
                    end
                    else if (is_op_char(c))
                    begin
                        held_next = c;
                        mode_next = MODE_OP;
                    end
                    else
                    begin
                        slot_c[1]  = mk(KIND_SINGLE, c, pos, nxt, 64'd0, line_reg);
                        valid_c[1] = 1'b1;
                    end
                end
            end

            line_next = (bump && (line_reg != 16'hFFFF)) ? line_reg + 16'd1 : line_reg;

            // end of text: flush pending token, then the end token
            if (end_of_text && !halted_next)
            begin
                unique case (mode_next)
                    MODE_SLASH:
                    begin
                        slot_c[2]  = mk(KIND_SINGLE, "/", tstart_next, nxt, 64'd0, tline_next);
                        valid_c[2] = 1'b1;
                    end
                    MODE_STRING, MODE_ESC:
                    begin
                        slot_c[2]   = mk(KIND_ERR, ERR_STRING, tstart_next, nxt, 64'd0,
                                         tline_next);
                        valid_c[2]  = 1'b1;
                        halted_next = 1'b1;
                    end
                    MODE_HEXS:
                    begin
                        slot_c[2]   = mk(KIND_ERR, ERR_HEX, tstart_next, nxt, 64'd0, tline_next);
                        valid_c[2]  = 1'b1;
                        halted_next = 1'b1;
                    end
                    MODE_ZERO, MODE_HEX, MODE_DEC:
                    begin
                        slot_c[2]  = mk(KIND_NUM, 8'd0, tstart_next, nxt, acc_next, tline_next);
                        valid_c[2] = 1'b1;
                    end
                    MODE_IDENT:
                    begin
                        slot_c[2]  = mk(ident_kind(prefix_next, ilen_next), 8'd0, tstart_next,
                                        nxt, 64'd0, tline_next);
                        valid_c[2] = 1'b1;
                    end
                    MODE_OP:
                    begin
                        slot_c[2]  = mk(KIND_SINGLE, held_next, tstart_next, nxt, 64'd0,
                                        tline_next);
                        valid_c[2] = 1'b1;
                    end
                    default:
                    begin
                        valid_c[2] = 1'b0;
                    end
                endcase
                if (!halted_next)
                begin
                    slot_c[3]  = mk(KIND_END, 8'd0, nxt, nxt, 64'd0, line_next);
                    valid_c[3] = 1'b1;
                end
            end
        end
        else
        begin
            line_next = line_reg;
        end

        for (int i = 0; i < SLOTS; i++)
        begin
            later = 1'b0;
            for (int j = i + 1; j < SLOTS; j++)
            begin
                later = later | valid_c[j];
            end
            slot_c[i].run_last = valid_c[i] & ~later;
        end

        if (end_of_text)
        begin
            mode_next   = MODE_IDLE;
            held_next   = 8'd0;
            offset_next = '0;
            tstart_next = '0;
            acc_next    = 64'd0;
            prefix_next = 32'd0;
            ilen_next   = 3'd0;
            line_next   = 16'd1;
            halted_next = 1'b0;
            tline_next  = 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            held_reg   <= 8'd0;
            offset_reg <= '0;
            tstart_reg <= '0;
            acc_reg    <= 64'd0;
            prefix_reg <= 32'd0;
            ilen_reg   <= 3'd0;
            line_reg   <= 16'd1;
            halted_reg <= 1'b0;
            tline_reg  <= 16'd1;
        end
        else if (step)
        begin
            mode_reg   <= mode_next;
            held_reg   <= held_next;
            offset_reg <= offset_next;
            tstart_reg <= tstart_next;
            acc_reg    <= acc_next;
            prefix_reg <= prefix_next;
            ilen_reg   <= ilen_next;
            line_reg   <= line_next;
            halted_reg <= halted_next;
            tline_reg  <= tline_next;
        end
    end

    assign slot       = slot_c;
    assign slot_valid = valid_c;

endmodule

@@ rtl/exl_queue.sv @@
// Result queue: takes up to four tokens per cycle in slot order, gives one per cycle while out_ready is high.
module exl_queue
    import exl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  res_t             slot [SLOTS],
    input  logic [SLOTS-1:0] slot_valid,
    output logic             room,
    output logic             out_valid,
    input  logic             out_ready,
    output res_t             out_data
);

    localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

    res_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [QPTR_W-1:0] wr_pos [SLOTS];
    logic [CNT_W-1:0]  n_push;
    logic              pop;

    always_comb
    begin
        logic [CNT_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            wr_pos[i] = wr_ptr_reg + QPTR_W'(acc);
            acc       = acc + CNT_W'(slot_valid[i]);
        end
        n_push = push ? acc : '0;
    end

    assign pop         = out_valid && out_ready;
    assign wr_ptr_next = wr_ptr_reg + QPTR_W'(n_push);
    assign rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
    assign count_next  = count_reg + n_push - CNT_W'(pop);
    assign room        = count_reg <= CNT_W'(QDEPTH - MAX_STEP);
    assign out_valid   = count_reg != '0;
    assign out_data    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (slot_valid[i])
                begin
                    mem_reg[wr_pos[i]] <= slot[i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ tb/exl_token_checker.sv @@
`timescale 1ns / 100ps
// Token checker for expression_lexer: predicts tokens from byte transfers and compares them.
module exl_token_checker
    import exl_pkg::*;
#(
    parameter int unsigned TEXT_WRAP = 65536
)
(
    input  logic        clk,
    input  logic        rst_n,
    exl_in_if           text_in,
    exl_out_if          token_out,
    output int unsigned mismatch_count,
    output int unsigned tokens_pending
);

    typedef enum logic [3:0] {
        SC_IDLE,
        SC_SLASH,
        SC_LINE,
        SC_BLOCK,
        SC_STAR,
        SC_STRING,
        SC_ESC,
        SC_ZERO,
        SC_HEX_START,
        SC_HEX,
        SC_DEC,
        SC_IDENT,
        SC_OP
    } scan_state_t;

    scan_state_t scan_st;
    logic [7:0]  pending_op;
    int unsigned text_pos;
    logic [15:0] tok_start;
    logic [15:0] tok_line;
    logic [15:0] line_ctr;
    logic [63:0] num_acc;
    logic [31:0] id_prefix;
    logic [2:0]  id_len;
    bit          halted;

    res_t        expected_tokens[$];
    res_t        step_toks[$];
    int unsigned err_total = 0;
    int unsigned tokens_seen = 0;

    function automatic void clear_scan();
        scan_st    = SC_IDLE;
        pending_op = 8'd0;
        text_pos   = 0;
        tok_start  = 16'd0;
        tok_line   = 16'd1;
        line_ctr   = 16'd1;
        num_acc    = 64'd0;
        id_prefix  = 32'd0;
        id_len     = 3'd0;
        halted     = 1'b0;
    endfunction

    function automatic void add_token(tok_kind_t kind, logic [7:0] code, logic [15:0] first,
                                      logic [15:0] past, logic [63:0] value, logic [15:0] line);
        res_t tok;
        if (step_toks.size() < MAX_STEP)
        begin
            tok.kind      = kind;
            tok.code      = code;
            tok.start_ofs = first;
            tok.end_ofs   = past;
            tok.value     = value;
            tok.line      = line;
            tok.run_last  = 1'b0;
            step_toks.insert(step_toks.size(), tok);
        end
    endfunction

    function automatic void flag_error(logic [7:0] code, logic [15:0] past);
        add_token(KIND_ERR, code, tok_start, past, 64'd0, tok_line);
        halted = 1'b1;
    endfunction

    function automatic void bump_line();
        if (line_ctr != 16'hFFFF)
            line_ctr = line_ctr + 16'd1;
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return c == "@" || c == "_" || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit is_op_lead(logic [7:0] c);
        return c == "<" || c == ">" || c == "!" || c == "=" || c == "&" || c == "|";
    endfunction

    function automatic int hex_val(logic [7:0] c);
        if (is_digit(c))
            return int'(c - 8'd48);
        if (c >= "A" && c <= "F")
            return int'(c - 8'd55);
        if (c >= "a" && c <= "f")
            return int'(c - 8'd87);
        return -1;
    endfunction

    function automatic int op_pair(logic [7:0] a, logic [7:0] b);
        case ({a, b})
            {"<", "="}: return int'(OP_LE);
            {"<", "<"}: return int'(OP_SHL);
            {">", "="}: return int'(OP_GE);
            {">", ">"}: return int'(OP_SHR);
            {"!", "="}: return int'(OP_NE);
            {"=", "="}: return int'(OP_EQ);
            {"&", "&"}: return int'(OP_LAND);
            {"|", "|"}: return int'(OP_LOR);
            default:    return -1;
        endcase
    endfunction

    function automatic void emit_word(logic [15:0] past);
        tok_kind_t kind;
        kind = KIND_IDENT;
        if (id_len == 3'd2 && id_prefix == KW_IF)
            kind = KIND_IF;
        else if (id_len == 3'd3 && id_prefix == KW_VAR)
            kind = KIND_VAR;
        else if (id_len == 3'd4 && id_prefix == KW_ELSE)
            kind = KIND_ELSE;
        add_token(kind, 8'd0, tok_start, past, 64'd0, tok_line);
    endfunction

    // a token ended by c is emitted, then c is scanned again from idle
    function automatic void scan_char(logic [7:0] c, logic [15:0] pos, logic [15:0] nxt);
        bit again;
        int v;
        again = 1'b1;
        while (again)
        begin
            again = 1'b0;
            case (scan_st)
                SC_IDLE:
                begin
                    if (c == "\n")
                        bump_line();
                    else if (c != " " && c != "\t" && c != 8'h0D)
                    begin
                        tok_start = pos;
                        tok_line  = line_ctr;
                        if (c == "/")
                            scan_st = SC_SLASH;
                        else if (c == "\"")
                        begin
                            tok_start = nxt;
                            scan_st   = SC_STRING;
                        end
                        else if (c == "0")
                        begin
                            num_acc = 64'd0;
                            scan_st = SC_ZERO;
                        end
                        else if (is_digit(c))
                        begin
                            num_acc = {56'd0, c - 8'd48};
                            scan_st = SC_DEC;
                        end
                        else if (is_alpha(c))
                        begin
                            id_prefix = {24'd0, c};
                            id_len    = 3'd1;
                            scan_st   = SC_IDENT;
                        end
                        else if (is_op_lead(c))
                        begin
                            pending_op = c;
                            scan_st    = SC_OP;
                        end
                        else
                            add_token(KIND_SINGLE, c, pos, nxt, 64'd0, tok_line);
                    end
                end
                SC_SLASH:
                begin
                    if (c == "/")
                        scan_st = SC_LINE;
                    else if (c == "*")
                        scan_st = SC_BLOCK;
                    else
                    begin
                        add_token(KIND_SINGLE, "/", tok_start, pos, 64'd0, tok_line);
                        scan_st = SC_IDLE;
                        again   = 1'b1;
                    end
                end
                SC_LINE:
                begin
                    if (c == "\n")
                    begin
                        bump_line();
                        scan_st = SC_IDLE;
                    end
                end
                SC_BLOCK:
                begin
                    if (c == "*")
                        scan_st = SC_STAR;
                    else if (c == "\n")
                        bump_line();
                end
                SC_STAR:
                begin
                    if (c == "/")
                        scan_st = SC_IDLE;
                    else if (c != "*")
                    begin
                        if (c == "\n")
                            bump_line();
                        scan_st = SC_BLOCK;
                    end
                end
                SC_STRING:
                begin
                    if (c == "\"")
                    begin
                        add_token(KIND_STR, 8'd0, tok_start, pos, 64'd0, tok_line);
                        scan_st = SC_IDLE;
                    end
                    else if (c == "\\")
                        scan_st = SC_ESC;
                    else if (c == "\n")
                        bump_line();
                    else if (c < CTRL_LIMIT && c != 8'h0D && c != "\t")
                        flag_error(ERR_STRING, pos);
                end
                SC_ESC:
                begin
                    if (c == "\n")
                        bump_line();
                    scan_st = SC_STRING;
                end
                SC_ZERO:
                begin
                    if (c == "x" || c == "X")
                        scan_st = SC_HEX_START;
                    else
                    begin
                        scan_st = SC_DEC;
                        again   = 1'b1;
                    end
                end
                SC_HEX_START:
                begin
                    v = hex_val(c);
                    if (v < 0)
                        flag_error(ERR_HEX, pos);
                    else
                    begin
                        num_acc = {60'd0, v[3:0]};
                        scan_st = SC_HEX;
                    end
                end
                SC_HEX:
                begin
                    v = hex_val(c);
                    if (v >= 0)
                        num_acc = {num_acc[59:0], v[3:0]};
                    else
                    begin
                        add_token(KIND_NUM, 8'd0, tok_start, pos, num_acc, tok_line);
                        scan_st = SC_IDLE;
                        again   = 1'b1;
                    end
                end
                SC_DEC:
                begin
                    if (is_digit(c))
                        num_acc = num_acc * 64'd10 + {56'd0, c - 8'd48};
                    else
                    begin
                        add_token(KIND_NUM, 8'd0, tok_start, pos, num_acc, tok_line);
                        scan_st = SC_IDLE;
                        again   = 1'b1;
                    end
                end
                SC_IDENT:
                begin
                    if (is_alpha(c) || is_digit(c))
                    begin
                        if (id_len < 3'd4)
                            id_prefix = {id_prefix[23:0], c};
                        if (id_len < 3'd5)
                            id_len = id_len + 3'd1;
                    end
                    else
                    begin
                        emit_word(pos);
                        scan_st = SC_IDLE;
                        again   = 1'b1;
                    end
                end
                SC_OP:
                begin
                    v = op_pair(pending_op, c);
                    scan_st = SC_IDLE;
                    if (v >= 0)
                        add_token(KIND_DOUBLE, 8'(v), tok_start, nxt, 64'd0, tok_line);
                    else
                    begin
                        add_token(KIND_SINGLE, pending_op, tok_start, pos, 64'd0, tok_line);
                        again = 1'b1;
                    end
                end
                default:
                begin
                    scan_st = SC_IDLE;
                    again   = 1'b1;
                end
            endcase
        end
    endfunction

    function automatic void flush_text(logic [15:0] past);
        case (scan_st)
            SC_SLASH:
                add_token(KIND_SINGLE, "/", tok_start, past, 64'd0, tok_line);
            SC_STRING, SC_ESC:
                flag_error(ERR_STRING, past);
            SC_ZERO, SC_HEX, SC_DEC:
                add_token(KIND_NUM, 8'd0, tok_start, past, num_acc, tok_line);
            SC_HEX_START:
                flag_error(ERR_HEX, past);
            SC_IDENT:
                emit_word(past);
            SC_OP:
                add_token(KIND_SINGLE, pending_op, tok_start, past, 64'd0, tok_line);
            default:
                ;
        endcase
        if (!halted)
            add_token(KIND_END, 8'd0, past, past, 64'd0, line_ctr);
    endfunction

    function automatic void predict_byte(logic [7:0] c, logic last);
        int unsigned next_pos;
        logic [15:0] pos;
        logic [15:0] nxt;
        next_pos = (text_pos + 1) % TEXT_WRAP;
        pos      = text_pos[15:0];
        nxt      = next_pos[15:0];
        step_toks.delete();
        if (!halted)
        begin
            scan_char(c, pos, nxt);
            if (last && !halted)
                flush_text(nxt);
        end
        text_pos = next_pos;
        if (last)
            clear_scan();
        if (step_toks.size() > 0)
            step_toks[step_toks.size() - 1].run_last = 1'b1;
        foreach (step_toks[i])
            expected_tokens.insert(expected_tokens.size(), step_toks[i]);
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] want,
                                   input logic [63:0] got);
        err_total++;
        $display("[%0t] token %0d: %s expected 0x%0h, got 0x%0h",
                 $time, tokens_seen, field, want, got);
    endtask

    task automatic check_token();
        res_t want;
        if (expected_tokens.size() == 0)
            report_mismatch("unexpected token, token_kind", 64'd0,
                            64'(token_out.token_kind));
        else
        begin
            want = expected_tokens.pop_front();
            if (token_out.token_kind !== want.kind)
                report_mismatch("token_kind", 64'(want.kind), 64'(token_out.token_kind));
            if (token_out.token_code !== want.code)
                report_mismatch("token_code", 64'(want.code), 64'(token_out.token_code));
            if (token_out.start_offset !== want.start_ofs)
                report_mismatch("start_offset", 64'(want.start_ofs),
                                64'(token_out.start_offset));
            if (token_out.end_offset !== want.end_ofs)
                report_mismatch("end_offset", 64'(want.end_ofs), 64'(token_out.end_offset));
            if (token_out.number_value !== want.value)
                report_mismatch("number_value", want.value, token_out.number_value);
            if (token_out.line_number !== want.line)
                report_mismatch("line_number", 64'(want.line), 64'(token_out.line_number));
            if (token_out.run_last !== want.run_last)
                report_mismatch("run_last", 64'(want.run_last), 64'(token_out.run_last));
        end
        tokens_seen++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_scan();
            expected_tokens.delete();
            tokens_pending <= 0;
            mismatch_count <= err_total;
        end
        else
        begin
            if (token_out.valid && token_out.ready)
                check_token();
            if (text_in.valid && text_in.ready)
                predict_byte(text_in.text_byte, text_in.end_of_text);
            mismatch_count <= err_total;
            tokens_pending <= unsigned'(expected_tokens.size());
        end
    end

endmodule

@@ tb/tb_expression_lexer.sv @@
`timescale 1ns / 100ps
// Testbench top for expression_lexer: text stimulus, token receiver, watchdog and verdict.
module tb_expression_lexer;

    localparam int unsigned GAP_MAX      = 12;
    localparam int unsigned HOLD_CYCLES  = 150;
    localparam int unsigned IDLE_LIMIT   = 2000;
    localparam int unsigned DRAIN_CYCLES = 24;
    localparam int unsigned RANDOM_BYTES = 16;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    int unsigned mismatches;
    int unsigned pending;
    int unsigned idle_cycles = 0;
    int unsigned random_bytes = 0;
    bit          tx_calm = 1'b0;
    bit          rx_calm = 1'b0;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;
    logic [7:0]  text_buf[$];

    string digits     = "0123456789";
    string hex_digits = "0123456789abcdefABCDEF";
    string word_lead  = "@_abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
    string op_pairs   = "<=<<>=>>!===&&||";
    string op_leads   = "<>!=&|/";
    string blanks     = " \t\015\n";
    string punct      = "()[]{};,.+-*%^~?:#$'";

    exl_in_if  text_if();
    exl_out_if token_if();

    expression_lexer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_in   (text_if),
        .token_out (token_if)
    );

    exl_token_checker u_token_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .text_in        (text_if),
        .token_out      (token_if),
        .mismatch_count (mismatches),
        .tokens_pending (pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int unsigned pick_gap(bit calm);
        return calm ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    function automatic void push_byte(logic [7:0] b);
        text_buf.insert(text_buf.size(), b);
    endfunction

    function automatic void push_str(string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] ch;
        ch = 8'($urandom_range(32, 126));
        return (ch == "\"" || ch == "\\") ? "a" : ch;
    endfunction

    function automatic void pick_word_char(bit lead_only);
        if (!lead_only && $urandom_range(0, 3) == 0)
            push_byte(digits[$urandom_range(0, 9)]);
        else
            push_byte(word_lead[$urandom_range(0, word_lead.len() - 1)]);
    endfunction

    // mostly well-formed tokens, some noise and broken pieces
    function automatic void build_random_text();
        int unsigned pieces;
        int unsigned sel;
        int unsigned n;
        pieces = $urandom_range(1, 5);
        repeat (pieces)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 12)
            begin
                n = $urandom_range(1, 22);
                repeat (n) push_byte(digits[$urandom_range(0, 9)]);
            end
            else if (sel < 22)
            begin
                push_str($urandom_range(0, 1) ? "0x" : "0X");
                n = $urandom_range(1, 18);
                repeat (n) push_byte(hex_digits[$urandom_range(0, 21)]);
            end
            else if (sel < 35)
            begin
                case ($urandom_range(0, 4))
                    0: push_str("if");
                    1: push_str("var");
                    2: push_str("else");
                    default:
                    begin
                        pick_word_char(1'b1);
                        n = $urandom_range(0, 6);
                        repeat (n) pick_word_char(1'b0);
                    end
                endcase
            end
            else if (sel < 45)
            begin
                push_byte("\"");
                n = $urandom_range(0, 6);
                repeat (n)
                begin
                    case ($urandom_range(0, 7))
                        0:
                        begin
                            push_byte("\\");
                            push_byte(8'($urandom_range(0, 255)));
                        end
                        1: push_byte("\n");
                        default: push_byte(plain_char());
                    endcase
                end
                if ($urandom_range(0, 9) != 0)
                    push_byte("\"");
            end
            else if (sel < 52)
            begin
                n = $urandom_range(0, 6);
                if ($urandom_range(0, 1))
                begin
                    push_str("//");
                    repeat (n) push_byte(plain_char());
                    push_byte("\n");
                end
                else
                begin
                    push_str("/*");
                    repeat (n)
                    begin
                        case ($urandom_range(0, 3))
                            0: push_byte("*");
                            1: push_byte("\n");
                            default: push_byte(plain_char());
                        endcase
                    end
                    push_str("*/");
                end
            end
            else if (sel < 70)
            begin
                if ($urandom_range(0, 1))
                begin
                    n = $urandom_range(0, 7);
                    push_byte(op_pairs[2 * n]);
                    push_byte(op_pairs[2 * n + 1]);
                end
                else
                    push_byte(op_leads[$urandom_range(0, 6)]);
            end
            else if (sel < 80)
                push_byte(blanks[$urandom_range(0, 3)]);
            else if (sel < 90)
                push_byte(punct[$urandom_range(0, punct.len() - 1)]);
            else if (sel < 95)
                push_byte(8'($urandom_range(0, 255)));
            else if ($urandom_range(0, 1))
            begin
                push_str("0x");
                push_byte(punct[$urandom_range(0, punct.len() - 1)]);
            end
            else
            begin
                push_str("\"a");
                push_byte(8'($urandom_range(0, 31)));
                push_str("b\"");
            end
            if ($urandom_range(0, 1))
                push_byte(" ");
        end
    endfunction

    // sends text_buf as one text, final byte flagged
    task automatic send_text(input bit burst);
        int unsigned gap;
        for (int i = 0; i < text_buf.size(); i++)
        begin
            gap = burst ? 0 : pick_gap(tx_calm);
            if (gap > 0)
            begin
                text_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            text_if.valid       <= 1'b1;
            text_if.text_byte   <= text_buf[i];
            text_if.end_of_text <= (i == text_buf.size() - 1);
            @(posedge clk);
            while (!text_if.ready) @(posedge clk);
        end
        text_buf.delete();
        tx_calm = ($urandom_range(0, 3) == 0);
    endtask

    initial
    begin
        text_if.valid       <= 1'b0;
        text_if.text_byte   <= 8'd0;
        text_if.end_of_text <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_str("if var else elsee");
        send_text(1'b0);
        push_str("a<=b<<c>=d>>!===&&||");
        send_text(1'b0);
        push_str("<a>!b=&|/g//x\n/");
        send_text(1'b0);
        push_str("/*c\n**/0XFFFFFFFFFFFFFFFFa");
        send_text(1'b0);
        push_str("\"a");
        push_byte(8'h01);
        push_str("\"");
        send_text(1'b0);
        push_str("\"a\\");
        send_text(1'b0);
        push_str("0xg");
        send_text(1'b0);
        push_str("0x");
        send_text(1'b0);
        push_byte(8'h00);
        push_byte(8'h80);
        push_byte(8'hFF);
        push_str("1/2/*z");
        send_text(1'b0);

        // receiver holds off while a dense text streams in
        hold_req = 1'b1;
        repeat (12) push_byte("(");
        send_text(1'b1);

        while (random_bytes < RANDOM_BYTES)
        begin
            build_random_text();
            random_bytes += unsigned'(text_buf.size());
            send_text(1'b0);
        end

        text_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("expression_lexer regression: pass");
        else
            $display("expression_lexer regression: fail");
        $finish;
    end

    initial
    begin
        int unsigned gap;
        int unsigned tokens_taken;
        tokens_taken = 0;
        token_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                token_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            gap = pick_gap(rx_calm);
            if (gap > 0)
            begin
                token_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            token_if.ready <= 1'b1;
            @(posedge clk);
            while (!token_if.valid) @(posedge clk);
            tokens_taken++;
            if (tokens_taken % 24 == 0)
                rx_calm = ($urandom_range(0, 2) == 0);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (text_if.valid && text_if.ready) || (token_if.valid && token_if.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("expression_lexer regression: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

@@ sim.f @@
rtl/exl_pkg.sv
rtl/exl_in_if.sv
rtl/exl_out_if.sv
rtl/exl_scan.sv
rtl/exl_queue.sv
rtl/expression_lexer.sv
tb/exl_token_checker.sv
tb/tb_expression_lexer.sv
